// File: rtl/pvq_pkg.sv
// PVRTC quad decoder: shared types, constants and decode functions.
// Depends on nothing; used by every module of the block.
`default_nettype none

package pvq_pkg;

    // default clamp for the log2 word counts
    localparam int unsigned PVQ_MAX_WORDS_LOG2 = 10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TWO_BPP = 2'd0,
        CFG_FLIP    = 2'd1,
        CFG_ACROSS  = 2'd2,
        CFG_DOWN    = 2'd3
    } t_cfg_idx;

    // one input word: a quad of compressed words and its position
    typedef struct packed {
        logic [31:0] p_modulation;
        logic [31:0] p_colour;
        logic [31:0] q_modulation;
        logic [31:0] q_colour;
        logic [31:0] r_modulation;
        logic [31:0] r_colour;
        logic [31:0] s_modulation;
        logic [31:0] s_colour;
        logic [9:0]  quad_x;
        logic [9:0]  quad_y;
    } t_in_word;

    // one output word: a pixel
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [12:0] pixel_x;
        logic [11:0] pixel_y;
        logic        last;
    } t_out_word;

    // configuration as seen by the issue stage
    typedef struct packed {
        logic       two_bpp;
        logic       flip;
        logic [3:0] across_log2;
        logic [3:0] down_log2;
    } t_cfg;

    // colour channels r, g, b, a (alpha in 5 bits, top bit always zero)
    typedef logic [3:0][4:0] t_col;

    // stage 1: weights, decoded colours, modulation, coordinates
    typedef struct packed {
        logic            two;
        logic [3:0][5:0] w;
        t_col [3:0]      ca;
        t_col [3:0]      cb;
        logic [3:0]      m;
        logic            punch;
        logic [12:0]     px;
        logic [11:0]     py;
        logic            last;
    } t_s1;

    // stage 2: upscaled colours A and B
    typedef struct packed {
        logic [3:0][7:0] a;
        logic [3:0][7:0] b;
        logic [3:0]      m;
        logic            punch;
        logic [12:0]     px;
        logic [11:0]     py;
        logic            last;
    } t_s2;

    // modulation code to weight, standard set
    function automatic logic [3:0] f_rep(input logic [1:0] code);
        logic [3:0] res;
        case (code)
            2'd0:    res = 4'd0;
            2'd1:    res = 4'd3;
            2'd2:    res = 4'd5;
            default: res = 4'd8;
        endcase
        return res;
    endfunction

    // modulation code to weight, punch-through set
    function automatic logic [3:0] f_punch(input logic [1:0] code);
        logic [3:0] res;
        case (code)
            2'd0:    res = 4'd0;
            2'd1:    res = 4'd4;
            2'd2:    res = 4'd14;
            default: res = 4'd8;
        endcase
        return res;
    endfunction

    // colour A of a colour half
    function automatic t_col f_col_a(input logic [31:0] c);
        t_col res;
        if (c[15]) begin
            res[0] = c[14:10];
            res[1] = c[9:5];
            res[2] = {c[4:1], c[4]};
            res[3] = 5'd15;
        end else begin
            res[0] = {c[11:8], c[11]};
            res[1] = {c[7:4], c[7]};
            res[2] = {c[3:1], c[3:2]};
            res[3] = {1'b0, c[14:12], 1'b0};
        end
        return res;
    endfunction

    // colour B of a colour half
    function automatic t_col f_col_b(input logic [31:0] c);
        t_col res;
        if (c[31]) begin
            res[0] = c[30:26];
            res[1] = c[25:21];
            res[2] = c[20:16];
            res[3] = 5'd15;
        end else begin
            res[0] = {c[27:24], c[27]};
            res[1] = {c[23:20], c[23]};
            res[2] = {c[19:16], c[19]};
            res[3] = {1'b0, c[30:28], 1'b0};
        end
        return res;
    endfunction

    // 2bpp stored modulation code at row r (0..7), column c (0..15) of the quad
    function automatic logic [1:0] f_code2(input logic [3:0][31:0] mods,
                                           input logic [3:0][31:0] cols,
                                           input logic [2:0] r,
                                           input logic [3:0] c);
        logic [1:0]  w;
        logic [31:0] b;
        logic [31:0] t;
        logic [3:0]  k;
        logic [4:0]  bi;
        logic [1:0]  res;
        w  = {r[2], c[3]};
        b  = mods[w];
        t  = b;
        k  = {r[1:0], c[2:1]};
        bi = {r[1:0], c[2:0]};
        if (cols[w][0]) begin
            // interpolated words: bit 0 takes bit 1, bit 20 may take bit 21
            t[20] = b[0] ? b[21] : b[20];
            t[0]  = b[1];
            if (r[0] == c[0]) begin
                res = t[{k, 1'b0} +: 2];
            end else begin
                res = 2'd0;
            end
        end else begin
            res = b[bi] ? 2'd3 : 2'd0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pvq_issue.sv
// PVRTC quad decoder: quad buffer, pixel sequencer and stage 1 register.
// Depends on pvq_pkg.
`default_nettype none

module pvq_issue import pvq_pkg::*; #(
    parameter int unsigned MAX_WORDS_LOG2 = PVQ_MAX_WORDS_LOG2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_valid,
    input  wire t_in_word i_in_word,
    output logic          o_stall,
    input  wire logic     i_adv,
    output logic          o_s1_valid,
    output t_s1           o_s1
);

    logic            r_busy, n_busy;
    logic [4:0]      r_cnt, n_cnt;
    t_in_word        r_quad;
    logic            r_s1_valid;
    t_s1             r_s1, n_s1;

    logic            two, last_pix, issue, accept;
    logic [2:0]      x;
    logic [1:0]      y;
    logic [3:0][31:0] mods, cols;
    logic [3:0]      la, ld;
    logic [4:0]      sh_x, sh_y;
    logic [12:0]     base_x, mask_x;
    logic [11:0]     base_y, mask_y, py;
    logic [3:0]      cw, wx0;
    logic [2:0]      wy0;
    // 2bpp modulation
    logic [2:0]      r2;
    logic [3:0]      c2;
    logic [1:0]      w2, mode2;
    logic [3:0]      m_c, m_u, m_d, m_l, m_r, m2;
    logic [5:0]      sum4;
    logic [4:0]      sum_h, sum_v;
    // 4bpp modulation
    logic [2:0]      r4, c4;
    logic [1:0]      w4, code4;
    logic [3:0]      pv4;

    assign two      = i_cfg.two_bpp;
    assign last_pix = two ? (r_cnt == 5'd31) : (r_cnt == 5'd15);
    assign issue    = r_busy & i_adv;
    assign o_stall  = r_busy & ~(issue & last_pix);
    assign accept   = i_valid & ~o_stall;

    // sequencer
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
        end else if (issue) begin
            n_cnt = r_cnt + 5'd1;
            if (last_pix) begin
                n_busy = 1'b0;
            end
        end
    end

    assign x = two ? r_cnt[2:0] : {1'b0, r_cnt[1:0]};
    assign y = two ? r_cnt[4:3] : r_cnt[3:2];

    assign mods = {r_quad.s_modulation, r_quad.r_modulation,
                   r_quad.q_modulation, r_quad.p_modulation};
    assign cols = {r_quad.s_colour, r_quad.r_colour,
                   r_quad.q_colour, r_quad.p_colour};

    // 2bpp modulation with neighbor interpolation
    always_comb begin
        r2    = {1'b0, y} + 3'd2;
        c2    = {1'b0, x} + 4'd4;
        w2    = {r2[2], c2[3]};
        mode2 = cols[w2][0] ? (mods[w2][0] ? (mods[w2][20] ? 2'd3 : 2'd2) : 2'd1) : 2'd0;
        m_c   = f_rep(f_code2(mods, cols, r2, c2));
        m_u   = f_rep(f_code2(mods, cols, r2 - 3'd1, c2));
        m_d   = f_rep(f_code2(mods, cols, r2 + 3'd1, c2));
        m_l   = f_rep(f_code2(mods, cols, r2, c2 - 4'd1));
        m_r   = f_rep(f_code2(mods, cols, r2, c2 + 4'd1));
        sum4  = 6'(m_u) + 6'(m_d) + 6'(m_l) + 6'(m_r) + 6'd2;
        sum_h = 5'(m_l) + 5'(m_r) + 5'd1;
        sum_v = 5'(m_u) + 5'(m_d) + 5'd1;
        if (mode2 == 2'd0 || r2[0] == c2[0]) begin
            m2 = m_c;
        end else if (mode2 == 2'd1) begin
            m2 = sum4[5:2];
        end else if (mode2 == 2'd2) begin
            m2 = sum_h[4:1];
        end else begin
            m2 = sum_v[4:1];
        end
    end

    // 4bpp modulation, direct or punch-through
    always_comb begin
        r4    = {1'b0, y} + 3'd2;
        c4    = {1'b0, x[1:0]} + 3'd2;
        w4    = {r4[2], c4[2]};
        code4 = mods[w4][{r4[1:0], c4[1:0], 1'b0} +: 2];
        pv4   = cols[w4][0] ? f_punch(code4) : f_rep(code4);
    end

    // coordinates with wrap and flip
    always_comb begin
        la     = (i_cfg.across_log2 > 4'(MAX_WORDS_LOG2)) ? 4'(MAX_WORDS_LOG2)
                                                          : i_cfg.across_log2;
        ld     = (i_cfg.down_log2 > 4'(MAX_WORDS_LOG2)) ? 4'(MAX_WORDS_LOG2)
                                                        : i_cfg.down_log2;
        sh_x   = {1'b0, la} + (two ? 5'd3 : 5'd2);
        sh_y   = {1'b0, ld} + 5'd2;
        mask_x = ~(13'h1fff << sh_x);
        mask_y = ~(12'hfff << sh_y);
        base_x = (two ? {r_quad.quad_x, 3'b000} : {1'b0, r_quad.quad_x, 2'b00})
               + (two ? 13'd4 : 13'd2) + 13'(x);
        base_y = {r_quad.quad_y, 2'b00} + 12'd2 + 12'(y);
        py     = base_y & mask_y;
        if (i_cfg.flip) begin
            py = mask_y - py;
        end
    end

    // stage 1 payload
    always_comb begin
        cw  = two ? 4'd8 : 4'd4;
        wx0 = cw - 4'(x);
        wy0 = 3'd4 - 3'(y);
        n_s1.two  = two;
        n_s1.w[0] = 6'(wx0 * wy0);
        n_s1.w[1] = 6'(4'(x) * wy0);
        n_s1.w[2] = 6'(wx0 * 3'(y));
        n_s1.w[3] = 6'(4'(x) * 3'(y));
        for (int k = 0; k < 4; k++) begin
            n_s1.ca[k] = f_col_a(cols[k]);
            n_s1.cb[k] = f_col_b(cols[k]);
        end
        if (two) begin
            n_s1.m     = m2;
            n_s1.punch = 1'b0;
        end else if (pv4 > 4'd10) begin
            n_s1.m     = pv4 - 4'd10;
            n_s1.punch = 1'b1;
        end else begin
            n_s1.m     = pv4;
            n_s1.punch = 1'b0;
        end
        n_s1.px   = base_x & mask_x;
        n_s1.py   = py;
        n_s1.last = last_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cnt      <= 5'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            if (i_adv) begin
                r_s1_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_quad <= i_in_word;
        end
        if (issue) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    // an idle sequencer never holds off the source
    a_idle_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !o_stall) else $error("stall raised while idle");

    // a new quad starts at its first pixel
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_busy && r_cnt == 5'd0))
        else $error("quad did not start at pixel 0");

    // a held pipeline keeps the pixel count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_adv) |=> (r_busy && $stable(r_cnt)))
        else $error("pixel count moved while held");

endmodule

`default_nettype wire

// File: rtl/pvq_upscale.sv
// PVRTC quad decoder: bilinear upscale of colours A and B (stage 2).
// Depends on pvq_pkg.
`default_nettype none

module pvq_upscale import pvq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_s1_valid,
    input  wire t_s1  i_s1,
    output logic      o_s2_valid,
    output t_s2       o_s2
);

    logic r_s2_valid;
    t_s2  r_s2, n_s2;

    // expand a weighted sum to 8 bits
    function automatic logic [7:0] f_scale(input logic [11:0] v, input logic two,
                                           input logic alpha);
        logic [11:0] res;
        if (two) begin
            res = alpha ? ((v >> 5) + (v >> 1)) : ((v >> 7) + (v >> 2));
        end else begin
            res = alpha ? ((v >> 4) + v) : ((v >> 6) + (v >> 1));
        end
        return res[7:0];
    endfunction

    always_comb begin
        logic [11:0] va, vb;
        n_s2.m     = i_s1.m;
        n_s2.punch = i_s1.punch;
        n_s2.px    = i_s1.px;
        n_s2.py    = i_s1.py;
        n_s2.last  = i_s1.last;
        for (int ch = 0; ch < 4; ch++) begin
            va = 12'd0;
            vb = 12'd0;
            for (int k = 0; k < 4; k++) begin
                va = va + 12'(i_s1.w[k]) * 12'(i_s1.ca[k][ch]);
                vb = vb + 12'(i_s1.w[k]) * 12'(i_s1.cb[k][ch]);
            end
            n_s2.a[ch] = f_scale(va, i_s1.two, ch == 3);
            n_s2.b[ch] = f_scale(vb, i_s1.two, ch == 3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

`default_nettype wire

// File: rtl/pvq_blend.sv
// PVRTC quad decoder: per-pixel blend of A and B into the output register.
// Depends on pvq_pkg.
`default_nettype none

module pvq_blend import pvq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_s2_valid,
    input  wire t_s2  i_s2,
    output logic      o_valid,
    output t_out_word o_out_word
);

    logic            r_valid;
    t_out_word       r_out, n_out;
    logic [3:0][7:0] v;

    always_comb begin
        logic [11:0] s;
        for (int ch = 0; ch < 4; ch++) begin
            s = 12'(i_s2.a[ch]) * 12'(4'd8 - i_s2.m) + 12'(i_s2.b[ch]) * 12'(i_s2.m);
            v[ch] = s[10:3];
        end
        n_out.red     = v[0];
        n_out.green   = v[1];
        n_out.blue    = v[2];
        n_out.alpha   = i_s2.punch ? 8'd0 : v[3];
        n_out.pixel_x = i_s2.px;
        n_out.pixel_y = i_s2.py;
        n_out.last    = i_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_word = r_out;

endmodule

`default_nettype wire

// File: rtl/pvrtc_quad_decoder_unit.sv
// PVRTC quad decoder top level: configuration registers and the pixel pipeline.
// Depends on pvq_pkg, pvq_issue, pvq_upscale, pvq_blend.
//
// Usage:
//   Input channel (i_valid / o_stall, i_in_word) takes one quad of four
//   compressed words with the word position of the top-left one.
//   Output channel (o_valid / i_stall, o_out_word) gives 16 pixels per quad
//   in 4bpp mode and 32 in 2bpp mode, in raster order, last set on the final.
//   Configuration (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while no quad is in flight.
// Timing:
//   The first pixel of a quad passes the quad buffer, the stage 1 and stage 2
//   registers and the output register before it is on o_valid. One pixel
//   leaves per cycle, issued by the pixel sequencer, unless i_stall holds the
//   pipeline. The next quad is taken in the cycle the last pixel is issued.
// Reset: synchronous; clears all valid bits, the sequencer and configuration.
// Stall: i_stall freezes the whole pipeline while o_valid is set; nothing is
//   lost or repeated; o_stall rises once the sequencer cannot take a new quad.
`default_nettype none

module pvrtc_quad_decoder_unit import pvq_pkg::*; #(
    parameter int unsigned MAX_WORDS_LOG2 = PVQ_MAX_WORDS_LOG2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_in_word   i_in_word,
    output logic            o_stall,
    output logic            o_valid,
    output t_out_word       o_out_word,
    input  wire logic       i_stall,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_idx   i_cfg_index,
    input  wire logic [3:0] i_cfg_data
);

    t_cfg r_cfg;
    logic adv;
    logic s1_valid, s2_valid;
    t_s1  s1;
    t_s2  s2;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TWO_BPP: r_cfg.two_bpp     <= i_cfg_data[0];
                CFG_FLIP:    r_cfg.flip        <= i_cfg_data[0];
                CFG_ACROSS:  r_cfg.across_log2 <= i_cfg_data;
                CFG_DOWN:    r_cfg.down_log2   <= i_cfg_data;
                default:     r_cfg             <= r_cfg;
            endcase
        end
    end

    // whole pipeline moves unless a held output word blocks it
    assign adv = ~o_valid | ~i_stall;

    pvq_issue #(
        .MAX_WORDS_LOG2(MAX_WORDS_LOG2)
    ) u_issue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_in_word  (i_in_word),
        .o_stall    (o_stall),
        .i_adv      (adv),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    pvq_upscale u_upscale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s2_valid (s2_valid),
        .o_s2       (s2)
    );

    pvq_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_s2_valid (s2_valid),
        .i_s2       (s2),
        .o_valid    (o_valid),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

// File: dv/pvq_quad_checker.sv
// Watches the quad, pixel and configuration channels of the PVRTC quad decoder,
// predicts every pixel of each accepted quad and compares. Depends on pvq_pkg.
`timescale 1ns / 100ps

module pvq_quad_checker import pvq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_o_stall,
    input  wire logic      i_o_valid,
    input  wire t_out_word i_out_word,
    input  wire logic      i_stall,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_ready,
    input  wire t_cfg_idx  i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    output int             o_errors,
    output int             o_pending
);

    localparam int unsigned WORDS_LOG2_CAP = 10;

    // shadow copy of the configuration
    logic       two_bpp;
    logic       flip;
    logic [3:0] across_log2;
    logic [3:0] down_log2;

    // 4bpp weights or 2bpp codes and modes over the 2x2 word area, colours per word
    int unsigned mod_val[8][16];
    int unsigned mod_mode[8][16];
    int unsigned col_a[4][4];
    int unsigned col_b[4][4];

    t_out_word expected_pixels[$];

    function automatic int unsigned rep_weight(input int unsigned code);
        case (code & 3)
            0: return 0;
            1: return 3;
            2: return 5;
            default: return 8;
        endcase
    endfunction

    function automatic int unsigned punch_weight(input int unsigned code);
        case (code & 3)
            0: return 0;
            1: return 4;
            2: return 14;
            default: return 8;
        endcase
    endfunction

    // spread one word's modulation bits over its corner of the area
    function void unpack_mod(input int w, input logic [31:0] bits_in,
                             input logic [31:0] colour, input bit two);
        int unsigned c0, r0, mode;
        logic [31:0] bits;
        bits = bits_in;
        c0 = (w & 1) * (two ? 8 : 4);
        r0 = (w >> 1) * 4;
        mode = colour[0];
        if (!two) begin
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 4; x++) begin
                    mod_val[r0+y][c0+x] = mode ? punch_weight(bits[1:0])
                                               : rep_weight(bits[1:0]);
                    mod_mode[r0+y][c0+x] = 0;
                    bits = bits >> 2;
                end
        end else if (mode != 0) begin
            if (bits[0]) begin
                mode = bits[20] ? 3 : 2;
                bits[20] = bits[21];
            end
            bits[0] = bits[1];
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 8; x++) begin
                    mod_mode[r0+y][c0+x] = mode;
                    if (((x ^ y) & 1) == 0) begin
                        mod_val[r0+y][c0+x] = bits[1:0];
                        bits = bits >> 2;
                    end else begin
                        mod_val[r0+y][c0+x] = 0;
                    end
                end
        end else begin
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 8; x++) begin
                    mod_mode[r0+y][c0+x] = 0;
                    mod_val[r0+y][c0+x] = bits[0] ? 3 : 0;
                    bits = bits >> 1;
                end
        end
    endfunction

    function void decode_colours(input int w, input logic [31:0] c);
        if (c[15]) begin
            col_a[w][0] = c[14:10];
            col_a[w][1] = c[9:5];
            col_a[w][2] = (c & 32'h1e) | ((c & 32'h1e) >> 4);
            col_a[w][3] = 15;
        end else begin
            col_a[w][0] = ((c & 32'hf00) >> 7) | ((c & 32'hf00) >> 11);
            col_a[w][1] = ((c & 32'hf0) >> 3) | ((c & 32'hf0) >> 7);
            col_a[w][2] = ((c & 32'he) << 1) | ((c & 32'he) >> 2);
            col_a[w][3] = (c & 32'h7000) >> 11;
        end
        if (c[31]) begin
            col_b[w][0] = c[30:26];
            col_b[w][1] = c[25:21];
            col_b[w][2] = c[20:16];
            col_b[w][3] = 15;
        end else begin
            col_b[w][0] = ((c & 32'hf000000) >> 23) | ((c & 32'hf000000) >> 27);
            col_b[w][1] = ((c & 32'hf00000) >> 19) | ((c & 32'hf00000) >> 23);
            col_b[w][2] = ((c & 32'hf0000) >> 15) | ((c & 32'hf0000) >> 19);
            col_b[w][3] = (c & 32'h70000000) >> 27;
        end
    endfunction

    // bilinear upscale of one channel of colour A (sel 0) or B (sel 1)
    function automatic int unsigned upscale(input bit sel, input int ch,
                                            input int unsigned x, input int unsigned y,
                                            input bit two);
        int unsigned cw, v, c0, c1, c2, c3;
        cw = two ? 8 : 4;
        c0 = sel ? col_b[0][ch] : col_a[0][ch];
        c1 = sel ? col_b[1][ch] : col_a[1][ch];
        c2 = sel ? col_b[2][ch] : col_a[2][ch];
        c3 = sel ? col_b[3][ch] : col_a[3][ch];
        v = (cw - x) * (4 - y) * c0 + x * (4 - y) * c1 + (cw - x) * y * c2 + x * y * c3;
        if (two)
            return (ch == 3) ? (v >> 5) + (v >> 1) : (v >> 7) + (v >> 2);
        return (ch == 3) ? (v >> 4) + v : (v >> 6) + (v >> 1);
    endfunction

    function automatic int unsigned pixel_weight(input int unsigned r, input int unsigned c,
                                                 input bit two);
        int unsigned mode;
        if (!two) return mod_val[r][c];
        mode = mod_mode[r][c];
        if (mode == 0 || ((r ^ c) & 1) == 0)
            return rep_weight(mod_val[r][c]);
        if (mode == 1)
            return (rep_weight(mod_val[r-1][c]) + rep_weight(mod_val[r+1][c])
                  + rep_weight(mod_val[r][c-1]) + rep_weight(mod_val[r][c+1]) + 2) >> 2;
        if (mode == 2)
            return (rep_weight(mod_val[r][c-1]) + rep_weight(mod_val[r][c+1]) + 1) >> 1;
        return (rep_weight(mod_val[r-1][c]) + rep_weight(mod_val[r+1][c]) + 1) >> 1;
    endfunction

    // decode one quad into its pixels
    function void predict_quad(input t_in_word q);
        logic [3:0][31:0] mods, cols;
        int unsigned cw, la, ld, width, height, total, n, m, a, b, v, px, py;
        bit two, punch;
        t_out_word pix;
        int unsigned chan[4];
        two = two_bpp;
        cw = two ? 8 : 4;
        la = (across_log2 > WORDS_LOG2_CAP) ? WORDS_LOG2_CAP : across_log2;
        ld = (down_log2 > WORDS_LOG2_CAP) ? WORDS_LOG2_CAP : down_log2;
        width = (1 << la) * cw;
        height = (1 << ld) * 4;
        total = cw * 4;
        n = 0;
        mods = {q.s_modulation, q.r_modulation, q.q_modulation, q.p_modulation};
        cols = {q.s_colour, q.r_colour, q.q_colour, q.p_colour};
        for (int w = 0; w < 4; w++) begin
            unpack_mod(w, mods[w], cols[w], two);
            decode_colours(w, cols[w]);
        end
        for (int unsigned y = 0; y < 4; y++)
            for (int unsigned x = 0; x < cw; x++) begin
                m = pixel_weight(y + 2, x + cw / 2, two);
                punch = 0;
                if (m > 10) begin
                    punch = 1;
                    m -= 10;
                end
                for (int ch = 0; ch < 4; ch++) begin
                    a = upscale(0, ch, x, y, two);
                    b = upscale(1, ch, x, y, two);
                    v = (a * (8 - m) + b * m) >> 3;
                    if (ch == 3 && punch) v = 0;
                    chan[ch] = v & 8'hff;
                end
                px = (q.quad_x * cw + cw / 2 + x) & (width - 1);
                py = (q.quad_y * 4 + 2 + y) & (height - 1);
                if (flip) py = height - 1 - py;
                n++;
                pix.red     = 8'(chan[0]);
                pix.green   = 8'(chan[1]);
                pix.blue    = 8'(chan[2]);
                pix.alpha   = 8'(chan[3]);
                pix.pixel_x = px[12:0];
                pix.pixel_y = py[11:0];
                pix.last    = (n == total);
                expected_pixels.push_back(pix);
            end
    endfunction

    assign o_pending = expected_pixels.size();

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        t_out_word exp_pix;
        if (!i_rst_n) begin
            two_bpp <= 1'b0;
            flip <= 1'b0;
            across_log2 <= 4'd0;
            down_log2 <= 4'd0;
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TWO_BPP: two_bpp <= i_cfg_data[0];
                    CFG_FLIP:    flip <= i_cfg_data[0];
                    CFG_ACROSS:  across_log2 <= i_cfg_data;
                    CFG_DOWN:    down_log2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_o_stall)
                predict_quad(i_in_word);
            if (i_o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel word %h", i_out_word);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    if (exp_pix != i_out_word) begin
                        o_errors <= o_errors + 1;
                        if (exp_pix.red != i_out_word.red)
                            $error("red: expected %0d got %0d", exp_pix.red, i_out_word.red);
                        if (exp_pix.green != i_out_word.green)
                            $error("green: expected %0d got %0d",
                                   exp_pix.green, i_out_word.green);
                        if (exp_pix.blue != i_out_word.blue)
                            $error("blue: expected %0d got %0d", exp_pix.blue, i_out_word.blue);
                        if (exp_pix.alpha != i_out_word.alpha)
                            $error("alpha: expected %0d got %0d",
                                   exp_pix.alpha, i_out_word.alpha);
                        if (exp_pix.pixel_x != i_out_word.pixel_x)
                            $error("pixel_x: expected %0d got %0d",
                                   exp_pix.pixel_x, i_out_word.pixel_x);
                        if (exp_pix.pixel_y != i_out_word.pixel_y)
                            $error("pixel_y: expected %0d got %0d",
                                   exp_pix.pixel_y, i_out_word.pixel_y);
                        if (exp_pix.last != i_out_word.last)
                            $error("last: expected %0d got %0d", exp_pix.last, i_out_word.last);
                    end
                end
            end
        end
    end

endmodule

// File: dv/tb_pvrtc_quad_decoder_unit.sv
// Stimulus and verdict for the PVRTC quad decoder: quads, stalls and register phases.
// Depends on pvq_pkg, pvrtc_quad_decoder_unit and pvq_quad_checker.
`timescale 1ns / 100ps

module tb_pvrtc_quad_decoder_unit;
    import pvq_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    t_in_word   i_in_word;
    logic       o_stall;
    logic       o_valid;
    t_out_word  o_out_word;
    logic       i_stall;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic [3:0] i_cfg_data;
    int         error_count;
    int         pixels_pending;
    bit         no_idle;

    pvrtc_quad_decoder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_word(i_in_word), .o_stall(o_stall),
        .o_valid(o_valid), .o_out_word(o_out_word), .i_stall(i_stall),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pvq_quad_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_word(i_in_word), .i_o_stall(o_stall),
        .i_o_valid(o_valid), .i_out_word(o_out_word), .i_stall(i_stall),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(error_count), .o_pending(pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // pixel side: random stall before each word
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic logic [31:0] pattern(input int k);
        case (k % 6)
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h5555_5555;
            3: return 32'haaaa_aaaa;
            4: return 32'h8000_8001;
            default: return 32'h7fff_7ffe;
        endcase
    endfunction

    function automatic t_in_word make_quad(input int directed);
        t_in_word q;
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, 10'($urandom), 10'($urandom)};
        if (directed >= 0) begin
            q.p_modulation = pattern(directed);
            q.q_modulation = pattern(directed + 1);
            q.r_modulation = pattern(directed + 2);
            q.s_modulation = pattern(directed + 3);
            q.p_colour = pattern(directed + 4);
            q.q_colour = pattern(directed + 3);
            q.r_colour = pattern(directed + 5) ^ 32'(directed & 1);
            q.s_colour = pattern(directed);
            q.quad_x = (directed & 1) ? 10'h3ff : 10'h000;
            q.quad_y = (directed & 2) ? 10'h3ff : 10'h000;
        end
        return q;
    endfunction

    task automatic send_quad(input int directed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_word <= make_quad(directed);
        do @(posedge i_clk); while (o_stall);
    endtask

    // one register write, then the channel goes idle before the task returns
    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [3:0] across, down;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TWO_BPP;
        i_cfg_data = 4'd0;
        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first, then directed sweep in both word formats
        for (int k = 0; k < 12; k++) send_quad(k);
        drain();
        write_reg(CFG_TWO_BPP, 4'd1);
        write_reg(CFG_ACROSS, 4'd10);
        write_reg(CFG_DOWN, 4'd10);
        for (int k = 0; k < 12; k++) send_quad(k);
        drain();

        // directed then random phases across the register space, clamp values included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin across = 4'd0;  down = 4'd0;  end
                1: begin across = 4'd15; down = 4'd15; end
                2: begin across = 4'd10; down = 4'd0;  end
                3: begin across = 4'd0;  down = 4'd10; end
                default: begin
                    across = 4'($urandom_range(0, 15));
                    down = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_TWO_BPP, 4'(ph & 1));
            write_reg(CFG_FLIP, 4'((ph >> 1) & 1));
            write_reg(CFG_ACROSS, across);
            write_reg(CFG_DOWN, down);
            no_idle = (ph == 5);
            for (int k = 0; k < 32; k++) send_quad(-1);
            drain();
        end
        no_idle = 1'b0;

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
